### hdl/bcs_pkg.sv
// Shared types and constants for the battery charge supervisor.
package bcs_pkg;

    localparam int CNT_W   = 24;
    localparam int VOLT_W  = 23;
    localparam int CUR_W   = 18;
    localparam int HYST_W  = 4;
    localparam int ELAP_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int ZONE_W  = 3;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;
    localparam int SEL_W   = 2;

    typedef enum logic [1:0] {
        PH_GENERAL = 2'd0,
        PH_MAINT1  = 2'd1,
        PH_MAINT2  = 2'd2,
        PH_TIMEOUT = 2'd3
    } phase_t;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNPLUG = 2'd2;

    localparam logic [ZONE_W-1:0] ZONE_FREEZE = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_COLD   = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_NORMAL = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_WARM   = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_HOT    = 3'd4;

    localparam logic [SEL_W-1:0] RESUME_NONE   = 2'd0;
    localparam logic [SEL_W-1:0] RESUME_NORMAL = 2'd1;
    localparam logic [SEL_W-1:0] RESUME_MAINT  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_SAFETY_AC   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SAFETY_USB  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MAINT_FIRST = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAINT_SEC   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HYST        = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_CALL_VOLT   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MAINT1_VOLT = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_MAINT2_VOLT = 3'd7;

    localparam logic [VOLT_W-1:0] VOLT_MAX = 23'd4350000;

    typedef struct packed {
        logic [CNT_W-1:0]  safety_limit_ac;
        logic [CNT_W-1:0]  safety_limit_usb;
        logic [CNT_W-1:0]  maint_first_limit;
        logic [CNT_W-1:0]  maint_second_limit;
        logic [HYST_W-1:0] temp_hysteresis;
        logic [VOLT_W-1:0] call_voltage;
        logic [VOLT_W-1:0] maint_first_voltage;
        logic [VOLT_W-1:0] maint_second_voltage;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] safety_count;
        logic [CNT_W-1:0] maint_count;
        logic             resume_is_maint;
    } chg_state_t;

endpackage

### hdl/bcs_zone.sv
// Temperature zone classifier with hysteresis and multi-zone stepping.
module bcs_zone import bcs_pkg::*; (
    input  logic [OP_W-1:0]          opcode,
    input  phase_t                   phase,
    input  logic signed [TEMP_W-1:0] battery_temp,
    input  logic [HYST_W-1:0]        hyst,
    input  logic [ZONE_W-1:0]        zone_cur,
    output logic [ZONE_W-1:0]        zone_next
);

    function automatic logic signed [9:0] upper_bound(
        input logic [ZONE_W-1:0] z, input logic [HYST_W-1:0] h);
        logic signed [9:0] hx;
        hx = $signed({6'b0, h});
        case (z)
            ZONE_FREEZE: upper_bound = hx;
            ZONE_COLD:   upper_bound = 10'sd10 + hx;
            ZONE_NORMAL: upper_bound = 10'sd45;
            ZONE_WARM:   upper_bound = 10'sd60;
            default:     upper_bound = 10'sd255;
        endcase
    endfunction

    function automatic logic signed [9:0] lower_bound(
        input logic [ZONE_W-1:0] z, input logic [HYST_W-1:0] h);
        logic signed [9:0] hx;
        hx = $signed({6'b0, h});
        case (z)
            ZONE_FREEZE: lower_bound = -10'sd255;
            ZONE_COLD:   lower_bound = 10'sd0;
            ZONE_NORMAL: lower_bound = 10'sd10;
            ZONE_WARM:   lower_bound = 10'sd45 - hx;
            default:     lower_bound = 10'sd60 - hx;
        endcase
    endfunction

    logic signed [9:0]   t;
    logic [ZONE_W-1:0]   z;
    logic                done;

    assign t = {{2{battery_temp[TEMP_W-1]}}, battery_temp};

    always_comb begin
        z    = zone_cur;
        done = 1'b0;
        // climb or descend at most four zones, stop at the first one that holds t
        if (t > upper_bound(zone_cur, hyst)) begin
            for (int i = 0; i < 4; i++) begin
                if (!done && z < ZONE_HOT) begin
                    z = z + 3'd1;
                    if (upper_bound(z, hyst) > t) done = 1'b1;
                end
            end
        end else if (t < lower_bound(zone_cur, hyst)) begin
            for (int i = 0; i < 4; i++) begin
                if (!done && z > ZONE_FREEZE) begin
                    z = z - 3'd1;
                    if (lower_bound(z, hyst) < t) done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        zone_next = zone_cur;
        case (opcode)
            OP_TICK: begin
                if (phase != PH_TIMEOUT) zone_next = z;
            end
            OP_UNPLUG: zone_next = ZONE_NORMAL;
            default: zone_next = zone_cur;
        endcase
    end

endmodule

### hdl/bcs_timer.sv
// Charge phase sequencing with safety and maintenance timers.
module bcs_timer import bcs_pkg::*; (
    input  logic [OP_W-1:0]   opcode,
    input  logic [ELAP_W-1:0] elapsed_s,
    input  logic              charger_is_ac,
    input  logic              in_call,
    input  cfg_t              cfg,
    input  chg_state_t        st_cur,
    output chg_state_t        st_next
);

    logic [CNT_W:0]   sc_sum;
    logic [CNT_W:0]   mc_sum;
    logic [CNT_W-1:0] sc_sat;
    logic [CNT_W-1:0] mc_sat;
    logic [CNT_W-1:0] safety_lim;

    assign safety_lim = charger_is_ac ? cfg.safety_limit_ac : cfg.safety_limit_usb;
    assign sc_sum = {1'b0, st_cur.safety_count} + {{(CNT_W+1-ELAP_W){1'b0}}, elapsed_s};
    assign mc_sum = {1'b0, st_cur.maint_count} + {{(CNT_W+1-ELAP_W){1'b0}}, elapsed_s};
    // saturate at all ones
    assign sc_sat = sc_sum[CNT_W] ? {CNT_W{1'b1}} : sc_sum[CNT_W-1:0];
    assign mc_sat = mc_sum[CNT_W] ? {CNT_W{1'b1}} : mc_sum[CNT_W-1:0];

    always_comb begin
        st_next = st_cur;
        case (opcode)
            OP_TICK: begin
                if (st_cur.phase == PH_GENERAL && !in_call) begin
                    st_next.safety_count = sc_sat;
                    if (sc_sat >= safety_lim) st_next.phase = PH_TIMEOUT;
                end else if (st_cur.phase == PH_MAINT1) begin
                    st_next.maint_count = mc_sat;
                    if (mc_sat >= cfg.maint_first_limit) begin
                        st_next.phase           = PH_MAINT2;
                        st_next.resume_is_maint = 1'b1;
                    end
                end else if (st_cur.phase == PH_MAINT2) begin
                    if (mc_sat >= cfg.maint_second_limit) begin
                        st_next.maint_count     = '0;
                        st_next.phase           = PH_MAINT1;
                        st_next.resume_is_maint = 1'b1;
                    end else begin
                        st_next.maint_count = mc_sat;
                    end
                end
            end
            OP_DONE: begin
                if (st_cur.phase == PH_GENERAL) begin
                    st_next.phase           = PH_MAINT1;
                    st_next.safety_count    = '0;
                    st_next.maint_count     = '0;
                    st_next.resume_is_maint = 1'b1;
                end
            end
            OP_UNPLUG: begin
                st_next.phase           = PH_GENERAL;
                st_next.safety_count    = '0;
                st_next.maint_count     = '0;
                st_next.resume_is_maint = 1'b0;
            end
            default: st_next = st_cur;
        endcase
    end

endmodule

### hdl/bcs_limits.sv
// Current and voltage limit selection from zone, charger and phase.
module bcs_limits import bcs_pkg::*; (
    input  phase_t             phase,
    input  logic               resume_is_maint,
    input  logic [ZONE_W-1:0]  zone,
    input  logic               charger_is_ac,
    input  logic               in_call,
    input  logic               usb_boost,
    input  cfg_t               cfg,
    output logic [CUR_W-1:0]   current_limit,
    output logic [VOLT_W-1:0]  voltage_limit,
    output logic [1:0]         charge_state,
    output logic [ZONE_W-1:0]  temp_zone,
    output logic [SEL_W-1:0]   resume_delta_sel
);

    function automatic logic [VOLT_W-1:0] zone_volt(input logic [ZONE_W-1:0] z);
        case (z)
            ZONE_COLD:   zone_volt = 23'd4200000;
            ZONE_NORMAL: zone_volt = 23'd4350000;
            ZONE_WARM:   zone_volt = 23'd4200000;
            default:     zone_volt = '0;
        endcase
    endfunction

    function automatic logic [CUR_W-1:0] zone_cur(
        input logic [ZONE_W-1:0] z, input logic ac, input logic boost);
        zone_cur = '0;
        case (z)
            ZONE_COLD:   zone_cur = ac ? 18'd80000  : (boost ? 18'd120000 : 18'd50000);
            ZONE_NORMAL: zone_cur = ac ? 18'd150000 : (boost ? 18'd120000 : 18'd50000);
            ZONE_WARM:   zone_cur = ac ? 18'd80000  : (boost ? 18'd100000 : 18'd50000);
            default:     zone_cur = '0;
        endcase
    endfunction

    logic [ZONE_W-1:0] z;
    logic [VOLT_W-1:0] zv;
    logic [VOLT_W-1:0] req_volt;

    assign z  = (zone > ZONE_HOT) ? ZONE_HOT : zone;
    assign zv = zone_volt(z);

    always_comb begin
        if (in_call)                req_volt = cfg.call_voltage;
        else if (phase == PH_MAINT1) req_volt = cfg.maint_first_voltage;
        else if (phase == PH_MAINT2) req_volt = cfg.maint_second_voltage;
        else                        req_volt = '0;
    end

    always_comb begin
        if (phase == PH_TIMEOUT) begin
            current_limit = '0;
            voltage_limit = '0;
        end else begin
            current_limit = zone_cur(z, charger_is_ac, usb_boost);
            // zone ceiling wins when nothing is requested or the request is higher
            voltage_limit = (req_volt == '0 || req_volt > zv) ? zv : req_volt;
        end
    end

    assign charge_state     = phase;
    assign temp_zone        = z;
    assign resume_delta_sel = in_call ? RESUME_NONE :
                              (resume_is_maint ? RESUME_MAINT : RESUME_NORMAL);

endmodule

### hdl/battery_charge_supervisor.sv
// Top level of the battery charge supervisor: registers, handshakes, config.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid/s_ready + s_* event fields  | in
//  result  | m_valid/m_ready + m_* limit fields  | out
//  config  | cfg_valid/cfg_ready, cfg_index/data | in
//
// One item per clock sustained while results are taken; an accepted item is
// held in the input register while the zone, timer and limit logic settle
// into the result register.
// Reset is synchronous on aresetn low: state returns to general/normal zone
// and all configuration registers return to their defaults.
// A stalled result holds; the input register still takes one more item,
// after which s_ready drops until the result is taken. cfg_ready is always high.
module battery_charge_supervisor import bcs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic [ELAP_W-1:0]        s_elapsed_s,
    input  logic signed [TEMP_W-1:0] s_battery_temp,
    input  logic                     s_charger_is_ac,
    input  logic                     s_in_call,
    input  logic                     s_usb_boost,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CUR_W-1:0]         m_current_limit,
    output logic [VOLT_W-1:0]        m_voltage_limit,
    output logic [1:0]               m_charge_state,
    output logic [ZONE_W-1:0]        m_temp_zone,
    output logic [SEL_W-1:0]         m_resume_delta_sel,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CDATA_W-1:0]       cfg_data
);

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    logic [OP_W-1:0]          in_opcode_reg;
    logic [ELAP_W-1:0]        in_elapsed_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic                     in_ac_reg;
    logic                     in_call_reg;
    logic                     in_boost_reg;

    chg_state_t               st_reg;
    chg_state_t               st_next;
    logic [ZONE_W-1:0]        zone_reg;
    logic [ZONE_W-1:0]        zone_next;

    logic                     out_valid_reg;
    logic [CUR_W-1:0]         out_cur_reg;
    logic [VOLT_W-1:0]        out_volt_reg;
    logic [1:0]               out_state_reg;
    logic [ZONE_W-1:0]        out_zone_reg;
    logic [SEL_W-1:0]         out_sel_reg;

    logic [CUR_W-1:0]         cur_next;
    logic [VOLT_W-1:0]        volt_next;
    logic [1:0]               state_next;
    logic [ZONE_W-1:0]        tzone_next;
    logic [SEL_W-1:0]         sel_next;

    logic                     advance;
    logic                     in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign in_take   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    bcs_zone u_zone (
        .opcode       (in_opcode_reg),
        .phase        (st_reg.phase),
        .battery_temp (in_temp_reg),
        .hyst         (cfg_reg.temp_hysteresis),
        .zone_cur     (zone_reg),
        .zone_next    (zone_next)
    );

    bcs_timer u_timer (
        .opcode        (in_opcode_reg),
        .elapsed_s     (in_elapsed_reg),
        .charger_is_ac (in_ac_reg),
        .in_call       (in_call_reg),
        .cfg           (cfg_reg),
        .st_cur        (st_reg),
        .st_next       (st_next)
    );

    bcs_limits u_limits (
        .phase            (st_next.phase),
        .resume_is_maint  (st_next.resume_is_maint),
        .zone             (zone_next),
        .charger_is_ac    (in_ac_reg),
        .in_call          (in_call_reg),
        .usb_boost        (in_boost_reg),
        .cfg              (cfg_reg),
        .current_limit    (cur_next),
        .voltage_limit    (volt_next),
        .charge_state     (state_next),
        .temp_zone        (tzone_next),
        .resume_delta_sel (sel_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safety_limit_ac      <= 24'd36000;
            cfg_reg.safety_limit_usb     <= 24'd72000;
            cfg_reg.maint_first_limit    <= 24'd216000;
            cfg_reg.maint_second_limit   <= 24'd936000;
            cfg_reg.temp_hysteresis      <= 4'd3;
            cfg_reg.call_voltage         <= 23'd4200000;
            cfg_reg.maint_first_voltage  <= 23'd4200000;
            cfg_reg.maint_second_voltage <= 23'd4100000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SAFETY_AC:   cfg_reg.safety_limit_ac      <= cfg_data;
                CFG_SAFETY_USB:  cfg_reg.safety_limit_usb     <= cfg_data;
                CFG_MAINT_FIRST: cfg_reg.maint_first_limit    <= cfg_data;
                CFG_MAINT_SEC:   cfg_reg.maint_second_limit   <= cfg_data;
                CFG_HYST:        cfg_reg.temp_hysteresis      <= cfg_data[HYST_W-1:0];
                CFG_CALL_VOLT:   cfg_reg.call_voltage         <= cfg_data[VOLT_W-1:0];
                CFG_MAINT1_VOLT: cfg_reg.maint_first_voltage  <= cfg_data[VOLT_W-1:0];
                CFG_MAINT2_VOLT: cfg_reg.maint_second_voltage <= cfg_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_opcode_reg  <= s_opcode;
            in_elapsed_reg <= s_elapsed_s;
            in_temp_reg    <= s_battery_temp;
            in_ac_reg      <= s_charger_is_ac;
            in_call_reg    <= s_in_call;
            in_boost_reg   <= s_usb_boost;
        end
    end

    // supervisor state advances once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase           <= PH_GENERAL;
            st_reg.safety_count    <= '0;
            st_reg.maint_count     <= '0;
            st_reg.resume_is_maint <= 1'b0;
            zone_reg               <= ZONE_NORMAL;
        end else if (advance) begin
            st_reg   <= st_next;
            zone_reg <= zone_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_cur_reg   <= cur_next;
            out_volt_reg  <= volt_next;
            out_state_reg <= state_next;
            out_zone_reg  <= tzone_next;
            out_sel_reg   <= sel_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_current_limit    = out_cur_reg;
    assign m_voltage_limit    = out_volt_reg;
    assign m_charge_state     = out_state_reg;
    assign m_temp_zone        = out_zone_reg;
    assign m_resume_delta_sel = out_sel_reg;

endmodule

### hdl/bcs_checker.sv
// Port-level checks for the battery charge supervisor, bound to the top level.
module bcs_port_assert import bcs_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CUR_W-1:0]   m_current_limit,
    input logic [VOLT_W-1:0]  m_voltage_limit,
    input logic [1:0]         m_charge_state,
    input logic [ZONE_W-1:0]  m_temp_zone
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_limit)
            && $stable(m_voltage_limit) && $stable(m_charge_state)
            && $stable(m_temp_zone))
        else $error("result changed while stalled");

    // timeout drives both limits to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_charge_state == PH_TIMEOUT |->
            m_current_limit == '0 && m_voltage_limit == '0)
        else $error("nonzero limits in timeout");

    // freeze and hot zones allow no charging
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_temp_zone == ZONE_FREEZE || m_temp_zone == ZONE_HOT) |->
            m_current_limit == '0 && m_voltage_limit == '0)
        else $error("charging allowed in freeze or hot zone");

    // voltage never exceeds the normal-zone ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_voltage_limit <= VOLT_MAX)
        else $error("voltage limit above ceiling");

endmodule

bind battery_charge_supervisor bcs_port_assert u_bcs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_current_limit (m_current_limit),
    .m_voltage_limit (m_voltage_limit),
    .m_charge_state  (m_charge_state),
    .m_temp_zone     (m_temp_zone)
);
